/* rtl/core/multi_source_audio_fifo_mixer_macros.svh */
// assertion macros for the multi-source audio fifo mixer
// used by rtl/core modules that carry concurrent checks; no other dependencies
`ifndef MULTI_SOURCE_AUDIO_FIFO_MIXER_MACROS_SVH
`define MULTI_SOURCE_AUDIO_FIFO_MIXER_MACROS_SVH
`ifndef SYNTHESIS
// plain property, checked on every clock edge out of reset
`define MSAFM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("msafm check failed");
// same-cycle implication
`define MSAFM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("msafm check failed");
// next-cycle implication
`define MSAFM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("msafm check failed");
`else
`define MSAFM_ASSERT(lbl, clk, rst_n, prop)
`define MSAFM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define MSAFM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/msafm_pkg.sv */
// shared types and constants of the multi-source audio fifo mixer
// no dependencies; used by every module in rtl/core
package msafm_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int FRAME_W     = 2 * SAMPLE_W;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 2;

	// command kinds carried in tuser bit 0
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_PULL  = 1'b1;

	// channel count code meaning mono, every other code is stereo
	localparam logic [1:0] CH_MONO = 2'd1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HP_CHANNELS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIC_CHANNELS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AUDIO_ENABLE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIC_ENABLE   = 2'd3;

	typedef struct packed {
		logic [1:0] hp_channels;
		logic [1:0] mic_channels;
		logic       audio_enable;
		logic       mic_enable;
	} cfg_t;

	// one classified input item
	typedef struct packed {
		logic                is_pull;
		logic                src;
		logic [SAMPLE_W-1:0] right;
		logic [SAMPLE_W-1:0] left;
	} cmd_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SUM
	} eng_state_t;

endpackage

/* rtl/core/msafm_frame_mem.sv */
// frame memory of one source: one write port, one registered read port
// uses msafm_pkg for the frame width
module msafm_frame_mem #(
	parameter int DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [$clog2(DEPTH)-1:0]      wr_addr,
	input  logic [msafm_pkg::FRAME_W-1:0] wr_data,
	input  logic                          rd_en,
	input  logic [$clog2(DEPTH)-1:0]      rd_addr,
	output logic [msafm_pkg::FRAME_W-1:0] rd_data
);

	logic [msafm_pkg::FRAME_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/core/msafm_cmd_queue.sv */
// front end: accepts stream items, decodes them and queues them for the engine
// uses msafm_pkg for the item type and command codes
module msafm_cmd_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [31:0]            in_data,
	input  logic [1:0]             in_user,
	output logic                   out_valid,
	output msafm_pkg::cmd_item_t   out_item,
	input  logic                   out_pop
);

	msafm_pkg::cmd_item_t                 q_mem_q [msafm_pkg::QUEUE_DEPTH];
	logic [msafm_pkg::QPTR_W-1:0]         wr_ptr_q;
	logic [msafm_pkg::QPTR_W-1:0]         rd_ptr_q;
	logic [msafm_pkg::QCNT_W-1:0]         count_q;
	msafm_pkg::cmd_item_t                 dec_item;
	logic                                 push;
	logic                                 pop;

	// decode the incoming item
	always_comb begin
		dec_item.is_pull = (in_user[0] == msafm_pkg::CMD_PULL);
		dec_item.src     = in_user[1];
		dec_item.left    = in_data[msafm_pkg::SAMPLE_W-1:0];
		dec_item.right   = in_data[msafm_pkg::FRAME_W-1:msafm_pkg::SAMPLE_W];
	end

	assign in_ready  = (count_q != msafm_pkg::QCNT_W'(msafm_pkg::QUEUE_DEPTH));
	assign out_valid = (count_q != '0);
	assign out_item  = q_mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_pop && out_valid;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= dec_item;
		end
	end

	// queue pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/msafm_mix_engine.sv */
// back end: per-source frame fifos, pull sequencer, mixer and output register
// uses msafm_pkg, msafm_frame_mem and the assertion macros header
`include "multi_source_audio_fifo_mixer_macros.svh"

module msafm_mix_engine #(
	parameter int NUM_SOURCES = 2,
	parameter int FIFO_DEPTH  = 1024,
	parameter int MIX_FRAMES  = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  msafm_pkg::cfg_t                cfg,
	input  logic                           cmd_valid,
	input  msafm_pkg::cmd_item_t           cmd_item,
	output logic                           cmd_pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [msafm_pkg::SAMPLE_W-1:0] out_left,
	output logic [msafm_pkg::SAMPLE_W-1:0] out_right,
	output logic                           out_last
);

	localparam int PTR_W  = $clog2(FIFO_DEPTH);
	localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
	localparam int CNT_W  = (MIX_FRAMES > 1) ? $clog2(MIX_FRAMES) : 1;

	logic [PTR_W-1:0]              rd_ptr_q [NUM_SOURCES];
	logic [PTR_W-1:0]              wr_ptr_q [NUM_SOURCES];
	logic [FILL_W-1:0]             fill_q   [NUM_SOURCES];
	logic [msafm_pkg::FRAME_W-1:0] rd_data  [NUM_SOURCES];
	logic [NUM_SOURCES-1:0]        nonempty;
	logic [NUM_SOURCES-1:0]        fill_one;
	logic [NUM_SOURCES-1:0]        wr_hit;
	logic [NUM_SOURCES-1:0]        src_sel;
	logic [NUM_SOURCES-1:0]        src_mono;

	msafm_pkg::eng_state_t         state_q;
	msafm_pkg::eng_state_t         state_d;
	logic [CNT_W-1:0]              frame_cnt_q;
	logic                          last_q;
	logic                          do_write;
	logic                          do_read;
	logic                          out_free;
	logic                          out_load;
	logic [msafm_pkg::SAMPLE_W-1:0] sum_l;
	logic [msafm_pkg::SAMPLE_W-1:0] sum_r;

	assign out_free = !out_valid || out_ready;

	// per-source fifo bookkeeping and frame memory
	for (genvar g = 0; g < NUM_SOURCES; g++) begin : g_src
		localparam bit IS_HP  = (g == 0);
		localparam bit IS_MIC = (g == 1);

		assign nonempty[g] = (fill_q[g] != '0);
		assign fill_one[g] = (fill_q[g] == FILL_W'(1));
		assign wr_hit[g]   = do_write && (int'(cmd_item.src) == g)
			&& (fill_q[g] != FILL_W'(FIFO_DEPTH));
		assign src_mono[g] = (IS_HP && (cfg.hp_channels == msafm_pkg::CH_MONO))
			|| (IS_MIC && (cfg.mic_channels == msafm_pkg::CH_MONO));
		assign src_sel[g]  = (cfg.audio_enable && cfg.mic_enable)
			|| (cfg.audio_enable && IS_HP) || (cfg.mic_enable && IS_MIC);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rd_ptr_q[g] <= '0;
				wr_ptr_q[g] <= '0;
				fill_q[g]   <= '0;
			end else begin
				if (wr_hit[g]) begin
					wr_ptr_q[g] <= (wr_ptr_q[g] == PTR_W'(FIFO_DEPTH - 1)) ? '0
						: wr_ptr_q[g] + 1'b1;
					fill_q[g]   <= fill_q[g] + 1'b1;
				end else if (do_read) begin
					rd_ptr_q[g] <= (rd_ptr_q[g] == PTR_W'(FIFO_DEPTH - 1)) ? '0
						: rd_ptr_q[g] + 1'b1;
					fill_q[g]   <= fill_q[g] - 1'b1;
				end
			end
		end

		msafm_frame_mem #(
			.DEPTH (FIFO_DEPTH)
		) u_mem (
			.clk     (clk),
			.wr_en   (wr_hit[g]),
			.wr_addr (wr_ptr_q[g]),
			.wr_data ({cmd_item.right, cmd_item.left}),
			.rd_en   (do_read),
			.rd_addr (rd_ptr_q[g]),
			.rd_data (rd_data[g])
		);
	end

	// wrapping sum over the selected sources
	always_comb begin
		sum_l = '0;
		sum_r = '0;
		for (int s = 0; s < NUM_SOURCES; s++) begin
			if (src_sel[s]) begin
				sum_l = sum_l + rd_data[s][msafm_pkg::SAMPLE_W-1:0];
				sum_r = sum_r + (src_mono[s] ? rd_data[s][msafm_pkg::SAMPLE_W-1:0]
					: rd_data[s][msafm_pkg::FRAME_W-1:msafm_pkg::SAMPLE_W]);
			end
		end
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			msafm_pkg::ST_IDLE: begin
				if (cmd_valid && cmd_item.is_pull && (&nonempty)) begin
					state_d = msafm_pkg::ST_READ;
				end
			end
			msafm_pkg::ST_READ: begin
				state_d = msafm_pkg::ST_SUM;
			end
			msafm_pkg::ST_SUM: begin
				if (out_free) begin
					state_d = last_q ? msafm_pkg::ST_IDLE : msafm_pkg::ST_READ;
				end
			end
			default: begin
				state_d = msafm_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		cmd_pop  = 1'b0;
		do_write = 1'b0;
		do_read  = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			msafm_pkg::ST_IDLE: begin
				cmd_pop  = cmd_valid;
				do_write = cmd_valid && !cmd_item.is_pull;
			end
			msafm_pkg::ST_READ: begin
				do_read = 1'b1;
			end
			msafm_pkg::ST_SUM: begin
				out_load = out_free;
			end
			default: begin
				cmd_pop = 1'b0;
			end
		endcase
	end

	// state, frame count and last-frame flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= msafm_pkg::ST_IDLE;
			frame_cnt_q <= '0;
			last_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == msafm_pkg::ST_IDLE) begin
				frame_cnt_q <= '0;
			end else if (do_read) begin
				frame_cnt_q <= frame_cnt_q + 1'b1;
				last_q      <= (|fill_one) || (frame_cnt_q == CNT_W'(MIX_FRAMES - 1));
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_left  <= sum_l;
			out_right <= sum_r;
			out_last  <= last_q;
		end
	end

	// checks
	`MSAFM_ASSERT(a_fill_bound, clk, arst_n, fill_q[0] <= FILL_W'(FIFO_DEPTH))
	`MSAFM_ASSERT_IMPL(a_read_nonempty, clk, arst_n, state_q == msafm_pkg::ST_READ, &nonempty)
	`MSAFM_ASSERT_NEXT(a_read_then_sum, clk, arst_n, state_q == msafm_pkg::ST_READ,
		state_q == msafm_pkg::ST_SUM)
	`MSAFM_ASSERT_NEXT(a_pop_drops_fill, clk, arst_n, state_q == msafm_pkg::ST_READ,
		fill_q[1] == $past(fill_q[1]) - 1'b1)

endmodule

/* rtl/core/multi_source_audio_fifo_mixer.sv */
// top level of the multi-source audio fifo mixer: ports, config registers, hookup
// uses msafm_pkg, msafm_cmd_queue and msafm_mix_engine
//
// channel   direction  handshake               payload
// s_axis    in         s_axis_tvalid/tready    tdata {sample_right, sample_left}, tuser
// m_axis    out        m_axis_tvalid/tready    tdata {mix_right, mix_left}, tlast
// cfg       in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// a write is stored in the same cycle as it leaves the four-entry input queue
// a pull leaves idle, then steps through a memory read and a sum for each mixed frame
// the pull sequencer works on one item at a time; the input queue keeps accepting until full
// reset clears pointers and fill levels and sets config to its defaults; frame memory is not cleared
// a stalled output holds the engine in its sum step; writes wait behind the pull
module multi_source_audio_fifo_mixer #(
	parameter int NUM_SOURCES = 2,
	parameter int FIFO_DEPTH  = 1024,
	parameter int MIX_FRAMES  = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [31:0]                         s_axis_tdata,  // sample_left, sample_right
	input  logic [1:0]                          s_axis_tuser,  // cmd, source
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [31:0]                         m_axis_tdata,  // mix_left, mix_right
	output logic                                m_axis_tlast,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [msafm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [msafm_pkg::CFG_DATA_W-1:0]    cfg_data
);

	msafm_pkg::cfg_t                cfg_q;
	logic                           cmd_valid;
	msafm_pkg::cmd_item_t           cmd_item;
	logic                           cmd_pop;
	logic [msafm_pkg::SAMPLE_W-1:0] mix_left;
	logic [msafm_pkg::SAMPLE_W-1:0] mix_right;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hp_channels  <= 2'd2;
			cfg_q.mic_channels <= 2'd2;
			cfg_q.audio_enable <= 1'b1;
			cfg_q.mic_enable   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				msafm_pkg::REG_HP_CHANNELS:  cfg_q.hp_channels  <= cfg_data;
				msafm_pkg::REG_MIC_CHANNELS: cfg_q.mic_channels <= cfg_data;
				msafm_pkg::REG_AUDIO_ENABLE: cfg_q.audio_enable <= cfg_data[0];
				msafm_pkg::REG_MIC_ENABLE:   cfg_q.mic_enable   <= cfg_data[0];
			endcase
		end
	end

	// front end
	msafm_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.out_valid (cmd_valid),
		.out_item  (cmd_item),
		.out_pop   (cmd_pop)
	);

	// back end
	msafm_mix_engine #(
		.NUM_SOURCES (NUM_SOURCES),
		.FIFO_DEPTH  (FIFO_DEPTH),
		.MIX_FRAMES  (MIX_FRAMES)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd_item  (cmd_item),
		.cmd_pop   (cmd_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_left  (mix_left),
		.out_right (mix_right),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {mix_right, mix_left};

endmodule

/* dv/testbench.sv */
// self-checking testbench for multi_source_audio_fifo_mixer
// uses msafm_pkg and the rtl/core sources; an in-bench frame fifo model predicts the mixed stream
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int   NUM_SOURCES = 2;
	localparam int   FIFO_DEPTH  = 1024;
	localparam int   MIX_FRAMES  = 64;
	localparam real  CLK_PERIOD  = 10.0;
	localparam int   SETTLE      = 32;
	localparam int   DRAIN       = 64;
	localparam int   CYCLE_LIMIT = 2000000;
	localparam int   PHASE_ITEMS = 18;
	localparam int   SHOW_LIMIT  = 10;

	typedef enum logic [1:0] {ROW_WRITE, ROW_PULL, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t     kind;
		logic [1:0]    sel;      // source of a frame write, register index of a reg write
		logic [15:0]   left;     // register value sits in the low bits
		logic [15:0]   right;
		bit            typed;    // expectation given in the row, not by the model
		int            n_frames;
		logic [15:0]   exp_l;
		logic [15:0]   exp_r;
	} script_row_t;

	typedef struct packed {
		logic [15:0] left;
		logic [15:0] right;
		logic        last;
	} mix_frame_t;

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             s_axis_tvalid;
	logic                             s_axis_tready;
	logic [31:0]                      s_axis_tdata;   // sample_left, sample_right
	logic [1:0]                       s_axis_tuser;   // cmd, source
	logic                             m_axis_tvalid;
	logic                             m_axis_tready;
	logic [31:0]                      m_axis_tdata;   // mix_left, mix_right
	logic                             m_axis_tlast;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [msafm_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [msafm_pkg::CFG_DATA_W-1:0] cfg_data;

	// mixer model state
	logic [31:0]      frames_held [0:NUM_SOURCES-1][0:FIFO_DEPTH-1];
	int               rd_at [0:NUM_SOURCES-1];
	int               wr_at [0:NUM_SOURCES-1];
	int               queued [0:NUM_SOURCES-1];
	msafm_pkg::cfg_t  mix_cfg;

	mix_frame_t   mix_due [$];
	script_row_t  script [$];
	int           mismatches = 0;
	int           cycles = 0;
	int           burst_left = 0;
	int           stall_mode = 0;
	int           stall_left = 0;
	logic [15:0]  stall_bits = '0;

	multi_source_audio_fifo_mixer #(
		.NUM_SOURCES(NUM_SOURCES),
		.FIFO_DEPTH (FIFO_DEPTH),
		.MIX_FRAMES (MIX_FRAMES)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #(CLK_PERIOD / 2.0) clk = ~clk;

	// apply one accepted item to the model, queue the mixed frames it yields
	function automatic int mixer_take_item(input logic cmd, input logic src,
			input logic [15:0] left, input logic [15:0] right, input bit record);
		int          span;
		logic [15:0] sum_l;
		logic [15:0] sum_r;
		logic [15:0] smp_l;
		logic [15:0] smp_r;
		logic [31:0] entry;
		logic        mono;
		logic        picked;
		mix_frame_t  frame;
		if (cmd == msafm_pkg::CMD_WRITE) begin
			// full fifo drops the frame
			if (queued[src] < FIFO_DEPTH) begin
				frames_held[src][wr_at[src]] = {right, left};
				wr_at[src] = (wr_at[src] + 1) % FIFO_DEPTH;
				queued[src]++;
			end
			return 0;
		end
		span = MIX_FRAMES;
		for (int s = 0; s < NUM_SOURCES; s++) begin
			if (queued[s] < span)
				span = queued[s];
		end
		for (int f = 0; f < span; f++) begin
			sum_l = '0;
			sum_r = '0;
			for (int s = 0; s < NUM_SOURCES; s++) begin
				entry = frames_held[s][rd_at[s]];
				mono = (s == 0) ? (mix_cfg.hp_channels == msafm_pkg::CH_MONO)
					: (mix_cfg.mic_channels == msafm_pkg::CH_MONO);
				picked = (s == 0) ? mix_cfg.audio_enable : mix_cfg.mic_enable;
				smp_l = entry[15:0];
				smp_r = mono ? entry[15:0] : entry[31:16];
				if (picked) begin
					sum_l = sum_l + smp_l;
					sum_r = sum_r + smp_r;
				end
				rd_at[s] = (rd_at[s] + 1) % FIFO_DEPTH;
				queued[s]--;
			end
			frame.left = sum_l;
			frame.right = sum_r;
			frame.last = (f == span - 1);
			if (record)
				mix_due.push_back(frame);
		end
		return span;
	endfunction

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void add_row(input row_kind_t kind, input logic [1:0] sel,
			input logic [15:0] left, input logic [15:0] right, input bit typed,
			input int n_frames, input logic [15:0] exp_l, input logic [15:0] exp_r);
		script_row_t row;
		row.kind = kind;
		row.sel = sel;
		row.left = left;
		row.right = right;
		row.typed = typed;
		row.n_frames = n_frames;
		row.exp_l = exp_l;
		row.exp_r = exp_r;
		script.push_back(row);
	endfunction

	function automatic void log_mismatch(input string field, input logic [15:0] want,
			input logic [15:0] got);
		mismatches++;
		if (mismatches <= SHOW_LIMIT)
			$display("[%0t] mismatch on %s: expected %h, got %h", $realtime, field, want, got);
	endfunction

	// one input transfer; the sender runs in bursts with random gaps between them
	task automatic send_item(input logic cmd, input logic src, input logic [15:0] left,
			input logic [15:0] right, input bit record);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		end
		burst_left--;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {right, left};
		s_axis_tuser <= {src, cmd};
		do @(posedge clk); while (!s_axis_tready);
		void'(mixer_take_item(cmd, src, left, right, record));
	endtask

	// register writes happen only with the mixer drained and quiet
	task automatic write_reg(input logic [msafm_pkg::CFG_IDX_W-1:0] idx,
			input logic [msafm_pkg::CFG_DATA_W-1:0] value);
		s_axis_tvalid <= 1'b0;
		while (mix_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			msafm_pkg::REG_HP_CHANNELS:  mix_cfg.hp_channels = value;
			msafm_pkg::REG_MIC_CHANNELS: mix_cfg.mic_channels = value;
			msafm_pkg::REG_AUDIO_ENABLE: mix_cfg.audio_enable = value[0];
			msafm_pkg::REG_MIC_ENABLE:   mix_cfg.mic_enable = value[0];
			default: ;
		endcase
	endtask

	// receiver stall pattern, re-drawn when its random run length runs out
	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				stall_left <= $urandom_range(16, 96);
				stall_bits <= 16'($urandom);
			end else begin
				stall_left <= stall_left - 1;
			end
			case (stall_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				2: m_axis_tready <= stall_bits[stall_left % 16];
				default: m_axis_tready <= (stall_left % 16 == 0);
			endcase
		end else begin
			m_axis_tready <= 1'b0;
		end
	end

	// compare each output transfer with the oldest pending frame
	always @(posedge clk) begin : check_mix
		mix_frame_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (mix_due.size() == 0) begin
				log_mismatch("unexpected frame", 16'h0000, m_axis_tdata[15:0]);
			end else begin
				want = mix_due.pop_front();
				if (m_axis_tdata[15:0] !== want.left)
					log_mismatch("mix_left", want.left, m_axis_tdata[15:0]);
				if (m_axis_tdata[31:16] !== want.right)
					log_mismatch("mix_right", want.right, m_axis_tdata[31:16]);
				if (m_axis_tlast !== want.last)
					log_mismatch("last_frame", 16'(want.last), 16'(m_axis_tlast));
			end
		end
	end

	// run length guard
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		script_row_t      row;
		msafm_pkg::cfg_t  pick;
		logic [1:0]       junk;
		int               sent;
		int               n_hp;
		int               n_mic;
		logic             src_b;

		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		for (int s = 0; s < NUM_SOURCES; s++) begin
			rd_at[s] = 0;
			wr_at[s] = 0;
			queued[s] = 0;
		end
		mix_cfg.hp_channels = 2'd2;
		mix_cfg.mic_channels = 2'd2;
		mix_cfg.audio_enable = 1'b1;
		mix_cfg.mic_enable = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows: empty pulls, extremes, wrap, enables, mono and odd channel codes
		add_row(ROW_PULL,  2'd0, 16'h0000, 16'h0000, 1, 0, 16'h0000, 16'h0000);
		add_row(ROW_WRITE, 2'd0, 16'h7FFF, 16'h8000, 0, 0, 16'h0000, 16'h0000);
		add_row(ROW_PULL,  2'd1, 16'hFFFF, 16'hFFFF, 1, 0, 16'h0000, 16'h0000);
		add_row(ROW_WRITE, 2'd1, 16'h0001, 16'hFFFF, 0, 0, 16'h0000, 16'h0000);
		add_row(ROW_PULL,  2'd0, 16'h0000, 16'h0000, 1, 1, 16'h7FFF, 16'h8000);
		add_row(ROW_REG,   msafm_pkg::REG_MIC_ENABLE, 16'd1, 16'h0000, 0, 0,
			16'h0000, 16'h0000);
		add_row(ROW_WRITE, 2'd0, 16'h7FFF, 16'h8000, 0, 0, 16'h0000, 16'h0000);
		add_row(ROW_WRITE, 2'd1, 16'h0001, 16'h0001, 0, 0, 16'h0000, 16'h0000);
		add_row(ROW_PULL,  2'd0, 16'h0000, 16'h0000, 1, 1, 16'h8000, 16'h8001);
		add_row(ROW_REG,   msafm_pkg::REG_AUDIO_ENABLE, 16'd0, 16'h0000, 0, 0,
			16'h0000, 16'h0000);
		add_row(ROW_WRITE, 2'd0, 16'h1234, 16'h5678, 0, 0, 16'h0000, 16'h0000);
		add_row(ROW_WRITE, 2'd1, 16'h8000, 16'h7FFF, 0, 0, 16'h0000, 16'h0000);
		add_row(ROW_PULL,  2'd1, 16'h0000, 16'h0000, 1, 1, 16'h8000, 16'h7FFF);
		add_row(ROW_REG,   msafm_pkg::REG_AUDIO_ENABLE, 16'd1, 16'h0000, 0, 0,
			16'h0000, 16'h0000);
		add_row(ROW_REG,   msafm_pkg::REG_HP_CHANNELS, 16'(msafm_pkg::CH_MONO), 16'h0000,
			0, 0, 16'h0000, 16'h0000);
		add_row(ROW_WRITE, 2'd0, 16'h0005, 16'h0AAA, 0, 0, 16'h0000, 16'h0000);
		add_row(ROW_WRITE, 2'd1, 16'h0001, 16'h0002, 0, 0, 16'h0000, 16'h0000);
		add_row(ROW_PULL,  2'd0, 16'h0000, 16'h0000, 1, 1, 16'h0006, 16'h0007);
		add_row(ROW_REG,   msafm_pkg::REG_MIC_CHANNELS, 16'(msafm_pkg::CH_MONO), 16'h0000,
			0, 0, 16'h0000, 16'h0000);
		add_row(ROW_REG,   msafm_pkg::REG_HP_CHANNELS, 16'd0, 16'h0000, 0, 0,
			16'h0000, 16'h0000);
		add_row(ROW_WRITE, 2'd0, 16'hFFFF, 16'hFFFF, 0, 0, 16'h0000, 16'h0000);
		add_row(ROW_WRITE, 2'd1, 16'h0001, 16'h1234, 0, 0, 16'h0000, 16'h0000);
		add_row(ROW_PULL,  2'd0, 16'h0000, 16'h0000, 1, 1, 16'h0000, 16'h0000);
		add_row(ROW_REG,   msafm_pkg::REG_AUDIO_ENABLE, 16'd0, 16'h0000, 0, 0,
			16'h0000, 16'h0000);
		add_row(ROW_REG,   msafm_pkg::REG_MIC_ENABLE, 16'd0, 16'h0000, 0, 0,
			16'h0000, 16'h0000);
		add_row(ROW_WRITE, 2'd0, 16'h4321, 16'h8765, 0, 0, 16'h0000, 16'h0000);
		add_row(ROW_WRITE, 2'd1, 16'hABCD, 16'h0123, 0, 0, 16'h0000, 16'h0000);
		add_row(ROW_PULL,  2'd1, 16'h0000, 16'h0000, 1, 1, 16'h0000, 16'h0000);
		add_row(ROW_REG,   msafm_pkg::REG_HP_CHANNELS, 16'd3, 16'h0000, 0, 0,
			16'h0000, 16'h0000);
		add_row(ROW_REG,   msafm_pkg::REG_MIC_CHANNELS, 16'd2, 16'h0000, 0, 0,
			16'h0000, 16'h0000);
		add_row(ROW_REG,   msafm_pkg::REG_AUDIO_ENABLE, 16'd1, 16'h0000, 0, 0,
			16'h0000, 16'h0000);
		add_row(ROW_REG,   msafm_pkg::REG_MIC_ENABLE, 16'd1, 16'h0000, 0, 0,
			16'h0000, 16'h0000);
		// uneven fills: the pull takes the smaller one, then finds the mic side empty
		add_row(ROW_WRITE, 2'd0, 16'h0001, 16'h0002, 0, 0, 16'h0000, 16'h0000);
		add_row(ROW_WRITE, 2'd0, 16'h8000, 16'h8000, 0, 0, 16'h0000, 16'h0000);
		add_row(ROW_WRITE, 2'd0, 16'hFFFF, 16'h0000, 0, 0, 16'h0000, 16'h0000);
		add_row(ROW_WRITE, 2'd1, 16'h7FFF, 16'h7FFF, 0, 0, 16'h0000, 16'h0000);
		add_row(ROW_WRITE, 2'd1, 16'h8001, 16'hFFFE, 0, 0, 16'h0000, 16'h0000);
		add_row(ROW_PULL,  2'd0, 16'h0000, 16'h0000, 0, 0, 16'h0000, 16'h0000);
		add_row(ROW_PULL,  2'd1, 16'h0000, 16'h0000, 0, 0, 16'h0000, 16'h0000);

		foreach (script[i]) begin
			row = script[i];
			if (row.kind == ROW_REG) begin
				write_reg(row.sel, row.left[msafm_pkg::CFG_DATA_W-1:0]);
			end else begin
				send_item((row.kind == ROW_PULL) ? msafm_pkg::CMD_PULL : msafm_pkg::CMD_WRITE,
					row.sel[0], row.left, row.right, !row.typed);
				if (row.typed && row.n_frames != 0)
					mix_due.push_back('{left: row.exp_l, right: row.exp_r, last: 1'b1});
			end
		end

		// fill both fifos past one full-size pull, then pull until one of them is empty
		n_hp = MIX_FRAMES + 6 - queued[0];
		repeat (n_hp)
			send_item(msafm_pkg::CMD_WRITE, 1'b0, pick_sample(), pick_sample(), 1'b1);
		n_mic = MIX_FRAMES + 3 - queued[1];
		repeat (n_mic)
			send_item(msafm_pkg::CMD_WRITE, 1'b1, pick_sample(), pick_sample(), 1'b1);
		while (queued[0] != 0 && queued[1] != 0)
			send_item(msafm_pkg::CMD_PULL, 1'($urandom_range(0, 1)), pick_sample(),
				pick_sample(), 1'b1);
		send_item(msafm_pkg::CMD_PULL, 1'b0, pick_sample(), pick_sample(), 1'b1);

		// random phases, each under its own register setting
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: pick = '{hp_channels: 2'd2, mic_channels: 2'd2,
					audio_enable: 1'b1, mic_enable: 1'b1};
				1: pick = '{hp_channels: msafm_pkg::CH_MONO, mic_channels: msafm_pkg::CH_MONO,
					audio_enable: 1'b1, mic_enable: 1'b1};
				2: pick = '{hp_channels: 2'd0, mic_channels: 2'd3,
					audio_enable: 1'b0, mic_enable: 1'b1};
				3: pick = '{hp_channels: 2'd3, mic_channels: msafm_pkg::CH_MONO,
					audio_enable: 1'b1, mic_enable: 1'b0};
				4: pick = '{hp_channels: msafm_pkg::CH_MONO, mic_channels: 2'd2,
					audio_enable: 1'b0, mic_enable: 1'b0};
				default: pick = msafm_pkg::cfg_t'(6'($urandom));
			endcase
			write_reg(msafm_pkg::REG_HP_CHANNELS, pick.hp_channels);
			write_reg(msafm_pkg::REG_MIC_CHANNELS, pick.mic_channels);
			junk = 2'($urandom);
			write_reg(msafm_pkg::REG_AUDIO_ENABLE, {junk[1], pick.audio_enable});
			write_reg(msafm_pkg::REG_MIC_ENABLE, {junk[0], pick.mic_enable});

			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(0, 4) != 0) begin
					// write burst to both sources in random order, closed by a pull
					n_hp = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 24)
						: $urandom_range(0, 6);
					n_mic = n_hp + $urandom_range(0, 4) - 2;
					if (n_mic < 0)
						n_mic = 0;
					while (n_hp + n_mic > 0) begin
						src_b = (n_mic == 0 || (n_hp != 0 && $urandom_range(0, 1) == 0))
							? 1'b0 : 1'b1;
						send_item(msafm_pkg::CMD_WRITE, src_b, pick_sample(), pick_sample(),
							1'b1);
						if (src_b)
							n_mic--;
						else
							n_hp--;
						sent++;
					end
					send_item(msafm_pkg::CMD_PULL, 1'($urandom_range(0, 1)), pick_sample(),
						pick_sample(), 1'b1);
					sent++;
				end else begin
					// stray item of either kind
					send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						pick_sample(), pick_sample(), 1'b1);
					sent++;
				end
			end
		end

		s_axis_tvalid <= 1'b0;
		while (mix_due.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
